/* rtl/wrrs_pkg.sv */
// shared types and constants of the weighted random retry selector
package wrrs_pkg;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned ENTRY_W     = 3;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned WEIGHT_SLOT = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ACT_RUN     = 3'd0,
    ACT_AGAIN   = 3'd1,
    ACT_SUCCESS = 3'd2,
    ACT_FAILED  = 3'd3,
    ACT_STOPPED = 3'd4
  } action_e;

  typedef struct packed {
    logic              func;
    logic [FRAC_W-1:0] random_fraction;
    logic              child_succeeded;
    logic              stop_requested;
  } in_t;

  typedef struct packed {
    action_e            action;
    logic [ENTRY_W-1:0] entry;
  } out_t;

  // per-cell control from the round logic
  typedef struct packed {
    logic in_use;
    logic clr;
    logic set;
  } cell_ctrl_t;

endpackage

/* rtl/wrrs_cell.sv */
// one cell of the selection chain: visited flag, prefix add and interval compare
module wrrs_cell #(
  parameter int unsigned WB = 8,
  parameter int unsigned SW = 12,
  parameter int unsigned CW = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wrrs_pkg::cell_ctrl_t ctrl_i,
  input  logic [WB-1:0]       weight_i,
  input  logic [CW-1:0]       value_i,
  input  logic [SW-1:0]       start_i,
  input  logic                found_i,
  output logic [SW-1:0]       start_o,
  output logic                found_o,
  output logic                hit_o
);
  import wrrs_pkg::*;

  logic          visited_q;
  logic          active;
  logic [SW-1:0] end_sum;
  logic [CW-1:0] lo_bound;
  logic [CW-1:0] hi_bound;

  assign active   = ctrl_i.in_use & ~visited_q;
  assign end_sum  = start_i + SW'(weight_i);
  assign lo_bound = {start_i, FRAC_W'(0)};
  assign hi_bound = {end_sum, FRAC_W'(0)};
  assign hit_o    = active & ~found_i & (lo_bound < value_i) & (value_i <= hi_bound);
  assign found_o  = found_i | hit_o;
  assign start_o  = active ? end_sum : start_i;

  // round end wins over a failure mark in the same transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= 1'b0;
    end else if (ctrl_i.clr) begin
      visited_q <= 1'b0;
    end else if (ctrl_i.set) begin
      visited_q <= 1'b1;
    end
  end

endmodule

/* rtl/weighted_random_retry_selector_core.sv */
// top level of the weighted random retry selector
// Weighted random selection without replacement over up to MAX_ENTRIES entries. Write the
// packed weights (register 0) and the entry count (register 1) while idle. A draw transaction
// scales its 16-bit random fraction by the weight still in play and names the first unvisited
// entry whose prefix interval holds it; an outcome transaction reports success (round ends)
// or failure (entry removed, its weight taken off the scale). Every transaction returns
// exactly one result transaction. The 16 x 9 bit scaling multiply and the ripple of prefix
// sums through the row of cells are the single combinational path, and one transaction may
// enter every cycle while the skid register is empty. Results sit in an output register
// backed by a one-entry skid register, so input stays open while one result waits.
module weighted_random_retry_selector_core #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned WEIGHT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wrrs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wrrs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  wrrs_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output wrrs_pkg::out_t                      out_data_o
);
  import wrrs_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned SCW = WEIGHT_BITS + 1;                       // scale width
  localparam int unsigned SW = WEIGHT_BITS + $clog2(MAX_ENTRIES + 1);  // prefix sum width
  localparam int unsigned CW = FRAC_W + SW;                            // compare width
  localparam logic [SCW-1:0] SCALE_ONE = SCW'(1) << WEIGHT_BITS;

  // configuration registers
  logic [CFG_DATA_W-1:0] weights_q;
  logic [COUNT_W-1:0]    entry_count_q;

  // round state (visited marks live in the cells)
  logic [SCW-1:0]     scale_q, scale_d;
  logic [COUNT_W-1:0] attempts_q, attempts_d;
  logic               awaiting_q, awaiting_d;
  logic [IW-1:0]      picked_q, picked_d;

  // result path
  logic out_valid_q, skid_valid_q;
  out_t out_q, skid_q, result;

  logic                   accept, take;
  logic [COUNT_W-1:0]     n_use;
  logic [COUNT_W-1:0]     attempts_inc;
  logic [CW-1:0]          value;
  logic [WEIGHT_BITS-1:0] w_arr [MAX_ENTRIES];
  logic [SW-1:0]          start_c [MAX_ENTRIES+1];
  logic [MAX_ENTRIES:0]   found_c;
  logic [MAX_ENTRIES-1:0] hit;
  logic [IW-1:0]          pick;
  logic                   end_round;
  logic                   mark_fail;
  logic [WEIGHT_BITS-1:0] picked_w;
  cell_ctrl_t             ctrl [MAX_ENTRIES];

  assign accept = in_valid_i & in_ready_o;
  assign take   = out_valid_q & out_ready_i;

  // a count above the cell row counts as the full row
  assign n_use = (entry_count_q > COUNT_W'(MAX_ENTRIES)) ? COUNT_W'(MAX_ENTRIES) : entry_count_q;
  assign attempts_inc = attempts_q + COUNT_W'(1);

  // scaled draw value, units of 2^-16 of one weight step
  assign value = CW'(in_data_i.random_fraction * scale_q);

  // chain of cells: prefix start and found flag ripple from entry 0 upward
  assign start_c[0] = '0;
  assign found_c[0] = 1'b0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    assign w_arr[k]       = weights_q[k*WEIGHT_SLOT +: WEIGHT_BITS];
    assign ctrl[k].in_use = COUNT_W'(k) < n_use;
    assign ctrl[k].clr    = accept & end_round;
    assign ctrl[k].set    = accept & mark_fail & (picked_q == IW'(k));

    wrrs_cell #(
      .WB (WEIGHT_BITS),
      .SW (SW),
      .CW (CW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl[k]),
      .weight_i (w_arr[k]),
      .value_i  (value),
      .start_i  (start_c[k]),
      .found_i  (found_c[k]),
      .start_o  (start_c[k+1]),
      .found_o  (found_c[k+1]),
      .hit_o    (hit[k])
    );
  end

  // at most one cell hits, so an or of indices encodes it
  always_comb begin
    pick = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (hit[k]) begin
        pick = pick | IW'(k);
      end
    end
  end

  assign picked_w = w_arr[picked_q];

  // round control for one transaction
  always_comb begin
    scale_d       = scale_q;
    attempts_d    = attempts_q;
    awaiting_d    = awaiting_q;
    picked_d      = picked_q;
    end_round     = 1'b0;
    mark_fail     = 1'b0;
    result.action = ACT_AGAIN;
    result.entry  = '0;

    if (!in_data_i.func) begin
      if (awaiting_q) begin
        // repeat the pending pick
        result.action = ACT_RUN;
        result.entry  = ENTRY_W'(picked_q);
      end else if (attempts_q >= n_use) begin
        end_round     = 1'b1;
        result.action = ACT_FAILED;
      end else begin
        attempts_d = attempts_inc;
        if (!found_c[MAX_ENTRIES]) begin
          // empty draw still burns an attempt
          if (attempts_inc >= n_use) begin
            end_round     = 1'b1;
            result.action = ACT_FAILED;
          end else begin
            result.action = ACT_AGAIN;
          end
        end else if (in_data_i.stop_requested) begin
          end_round     = 1'b1;
          result.action = ACT_STOPPED;
        end else begin
          awaiting_d    = 1'b1;
          picked_d      = pick;
          result.action = ACT_RUN;
          result.entry  = ENTRY_W'(pick);
        end
      end
    end else if (!awaiting_q) begin
      result.action = ACT_AGAIN;
    end else if (in_data_i.child_succeeded) begin
      end_round     = 1'b1;
      result.action = ACT_SUCCESS;
    end else begin
      // failed entry leaves the wheel, scale saturates at zero
      mark_fail  = 1'b1;
      scale_d    = (scale_q > SCW'(picked_w)) ? scale_q - SCW'(picked_w) : '0;
      awaiting_d = 1'b0;
      picked_d   = '0;
      if (attempts_q >= n_use) begin
        end_round     = 1'b1;
        result.action = ACT_FAILED;
      end else begin
        result.action = ACT_AGAIN;
      end
    end

    if (end_round) begin
      scale_d    = SCALE_ONE;
      attempts_d = '0;
      awaiting_d = 1'b0;
      picked_d   = '0;
    end
  end

  // configuration and round state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q     <= '0;
      entry_count_q <= '0;
      scale_q       <= SCALE_ONE;
      attempts_q    <= '0;
      awaiting_q    <= 1'b0;
      picked_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WEIGHTS:     weights_q     <= cfg_data_i;
          CFG_ENTRY_COUNT: entry_count_q <= cfg_data_i[COUNT_W-1:0];
          default:         ;
        endcase
      end
      if (accept) begin
        scale_q    <= scale_d;
        attempts_q <= attempts_d;
        awaiting_q <= awaiting_d;
        picked_q   <= picked_d;
      end
    end
  end

  // output register plus skid register; input closes only when both hold results
  assign in_ready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      out_valid_q  <= skid_valid_q | accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : result;
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/wrrs_checker.sv */
// port-level checker for the weighted random retry selector, bound to the top level
module wrrs_checker #(
  parameter int unsigned MAX_ENTRIES = 8
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input wrrs_pkg::out_t                  out_data_o
);
  import wrrs_pkg::*;

  // a stalled result holds still
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // only a run result carries an entry
  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action != ACT_RUN |-> out_data_o.entry == '0)
    else $error("entry set on a non-run result");

  // a named entry lies within the cell row
  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.action == ACT_RUN |-> 32'(out_data_o.entry) < MAX_ENTRIES)
    else $error("run entry beyond the cell row");

  // input closes only behind a full output register
  a_ready_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // one result per transaction: with input closed and no result taken, input stays closed
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> !in_ready_o)
    else $error("skid register drained without a taken result");

endmodule

bind weighted_random_retry_selector_core wrrs_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_wrrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
